// ----- hw/rtl/pid_pkg.sv -----
// ---------------------------------------------------------------------------
// pid_pkg: shared types and constants of the clamped PID controller
// Field widths, register indexes, command codes and the configuration struct.
// ---------------------------------------------------------------------------
package pid_pkg;

  // Payload and register widths.
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 23;
  localparam int OUT_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = LIMIT_W;

  // Internal arithmetic widths.
  localparam int ERR_W   = SAMPLE_W + 1;    // setpoint minus measurement
  localparam int DIFF_W  = ERR_W + 1;       // error minus previous error
  localparam int SUM_W   = OUT_W;           // clamped error sum
  localparam int PROD_P_W = GAIN_W + ERR_W;
  localparam int PROD_I_W = GAIN_W + SUM_W;
  localparam int PROD_D_W = GAIN_W + DIFF_W;
  localparam int ACC_W    = PROD_I_W + 1;
  localparam int FRAC_W   = 8;              // Q8.8 gains
  localparam int SHIFT_W  = ACC_W - FRAC_W;

  // Reset values of the limit registers.
  localparam logic [LIMIT_W-1:0] RESET_DRIVE_LIMIT    = LIMIT_W'(999999);
  localparam logic [LIMIT_W-1:0] RESET_INTEGRAL_LIMIT = LIMIT_W'(8388607);

  // Command codes carried in the func field.
  typedef enum logic [1:0] {
    FUNC_MEAS  = 2'd0,
    FUNC_ERROR = 2'd1,
    FUNC_CLEAR = 2'd2
  } func_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_TARGET    = 3'd3,
    REG_OUT_LIMIT = 3'd4,
    REG_INT_LIMIT = 3'd5
  } reg_idx_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic signed [GAIN_W-1:0]   gain_p;
    logic signed [GAIN_W-1:0]   gain_i;
    logic signed [GAIN_W-1:0]   gain_d;
    logic signed [SAMPLE_W-1:0] target_value;
    logic [LIMIT_W-1:0]         drive_limit;
    logic [LIMIT_W-1:0]         integral_limit;
  } cfg_t;

endpackage

// ----- hw/rtl/pid_if.sv -----
// ---------------------------------------------------------------------------
// pid_if: valid/ready channels of the clamped PID controller
// One interface for the command stream and one for the control results.
// ---------------------------------------------------------------------------

// Command channel: one transaction per update or clear command.
interface pid_in_if
  import pid_pkg::*;
  ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 func;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output func, output sample, input ready);
  modport sink   (input valid, input func, input sample, output ready);
endinterface

// Result channel: one transaction per command.
interface pid_out_if
  import pid_pkg::*;
  ();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] control_out;

  modport source (output valid, output control_out, input ready);
  modport sink   (input valid, input control_out, output ready);
endinterface

// ----- hw/rtl/pid_cfg_regs.sv -----
// ---------------------------------------------------------------------------
// pid_cfg_regs: configuration register bank
// Holds gains, setpoint and limits; writes to unknown indexes are dropped.
// ---------------------------------------------------------------------------
module pid_cfg_regs
  import pid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output cfg_t                  cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Decode the write index into one register update.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_GAIN_P:    cfg_nxt.gain_p         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:    cfg_nxt.gain_i         = cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:    cfg_nxt.gain_d         = cfg_wdata[GAIN_W-1:0];
        REG_TARGET:    cfg_nxt.target_value   = cfg_wdata[SAMPLE_W-1:0];
        REG_OUT_LIMIT: cfg_nxt.drive_limit    = cfg_wdata[LIMIT_W-1:0];
        REG_INT_LIMIT: cfg_nxt.integral_limit = cfg_wdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_p         <= '0;
      cfg_r.gain_i         <= '0;
      cfg_r.gain_d         <= '0;
      cfg_r.target_value   <= '0;
      cfg_r.drive_limit    <= RESET_DRIVE_LIMIT;
      cfg_r.integral_limit <= RESET_INTEGRAL_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- hw/rtl/pid_controller_clamped.sv -----
// ---------------------------------------------------------------------------
// pid_controller_clamped: positional PID controller with clamped integral
// Four-stage pipeline: input register, error/integral update, gain
// multiplies, sum with shift and output saturation.
// ---------------------------------------------------------------------------
//
//   channel   direction  handshake        payload
//   in_ch     in         valid / ready    func[1:0], sample[15:0] signed
//   out_ch    out        valid / ready    control_out[23:0] signed
//   cfg_*     in         cfg_we           cfg_index[2:0], cfg_wdata[22:0]
//
// One command per cycle is accepted; each result passes the stage 1, stage 2 and
// result registers. The error and integral recurrence closes within stage 1,
// which sets that rate. When the result register is full and not taken, the
// whole pipeline holds and in_ch.ready drops. Reset empties the pipeline,
// zeroes the stored error and sum and loads the register defaults.
//
module pid_controller_clamped
  import pid_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  pid_in_if.sink                in_ch,
  pid_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg;

  // Stage 0: input register.
  logic                       v0_r;
  logic [1:0]                 func0_r;
  logic signed [SAMPLE_W-1:0] sample0_r;

  // Controller state.
  logic signed [ERR_W-1:0] prev_err_r;
  logic signed [SUM_W-1:0] err_sum_r;
  logic signed [ERR_W-1:0] prev_err_nxt;
  logic signed [SUM_W-1:0] err_sum_nxt;

  // Stage 1: error terms.
  logic                     v1_r, clr1_r;
  logic signed [ERR_W-1:0]  e1_r;
  logic signed [DIFF_W-1:0] diff1_r;
  logic signed [SUM_W-1:0]  sum1_r;

  // Stage 2: products.
  logic                       v2_r, clr2_r;
  logic signed [PROD_P_W-1:0] prod_p2_r;
  logic signed [PROD_I_W-1:0] prod_i2_r;
  logic signed [PROD_D_W-1:0] prod_d2_r;

  // Stage 3: result register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_data_r;
  logic signed [OUT_W-1:0] out_data_nxt;

  logic advance;
  logic clear0;
  logic signed [ERR_W-1:0]  e_nxt;
  logic signed [DIFF_W-1:0] diff_nxt;
  logic signed [SUM_W:0]    sum_raw;
  logic signed [SUM_W:0]    int_lim;
  logic signed [PROD_P_W-1:0] prod_p_nxt;
  logic signed [PROD_I_W-1:0] prod_i_nxt;
  logic signed [PROD_D_W-1:0] prod_d_nxt;
  logic signed [ACC_W-1:0]    acc;
  logic signed [SHIFT_W-1:0]  acc_shr;
  logic signed [SHIFT_W-1:0]  out_lim;

  pid_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The pipeline moves as a whole unless the result is stalled.
  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (advance) begin
      v0_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      func0_r   <= in_ch.func;
      sample0_r <= in_ch.sample;
    end
  end

  // Stage 1: form the error, its difference and the clamped integral.
  always_comb begin
    clear0   = (func0_r != FUNC_MEAS) && (func0_r != FUNC_ERROR);
    if (func0_r == FUNC_MEAS) begin
      e_nxt = ERR_W'(cfg.target_value) - ERR_W'(sample0_r);
    end else begin
      e_nxt = ERR_W'(sample0_r);
    end
    diff_nxt = DIFF_W'(e_nxt) - DIFF_W'(prev_err_r);
    int_lim  = (SUM_W+1)'(cfg.integral_limit);
    sum_raw  = (SUM_W+1)'(err_sum_r) + (SUM_W+1)'(e_nxt);
    if (sum_raw > int_lim) begin
      sum_raw = int_lim;
    end else if (sum_raw < -int_lim) begin
      sum_raw = -int_lim;
    end

    prev_err_nxt = prev_err_r;
    err_sum_nxt  = err_sum_r;
    if (advance && v0_r) begin
      if (clear0) begin
        prev_err_nxt = '0;
        err_sum_nxt  = '0;
      end else begin
        prev_err_nxt = e_nxt;
        err_sum_nxt  = sum_raw[SUM_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      err_sum_r  <= '0;
      v1_r       <= 1'b0;
    end else begin
      prev_err_r <= prev_err_nxt;
      err_sum_r  <= err_sum_nxt;
      if (advance) begin
        v1_r <= v0_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      clr1_r  <= clear0;
      e1_r    <= e_nxt;
      diff1_r <= diff_nxt;
      sum1_r  <= sum_raw[SUM_W-1:0];
    end
  end

  // Stage 2: three independent gain multiplies.
  assign prod_p_nxt = PROD_P_W'(cfg.gain_p) * PROD_P_W'(e1_r);
  assign prod_i_nxt = PROD_I_W'(cfg.gain_i) * PROD_I_W'(sum1_r);
  assign prod_d_nxt = PROD_D_W'(cfg.gain_d) * PROD_D_W'(diff1_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (advance) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      clr2_r    <= clr1_r;
      prod_p2_r <= prod_p_nxt;
      prod_i2_r <= prod_i_nxt;
      prod_d2_r <= prod_d_nxt;
    end
  end

  // Stage 3: add, floor shift out the fraction, saturate the drive value.
  always_comb begin
    acc     = ACC_W'(prod_p2_r) + ACC_W'(prod_i2_r) + ACC_W'(prod_d2_r);
    acc_shr = acc[ACC_W-1:FRAC_W];
    out_lim = SHIFT_W'(cfg.drive_limit);
    if (clr2_r) begin
      out_data_nxt = '0;
    end else if (acc_shr > out_lim) begin
      out_data_nxt = OUT_W'(out_lim);
    end else if (acc_shr < -out_lim) begin
      out_data_nxt = OUT_W'(-out_lim);
    end else begin
      out_data_nxt = acc_shr[OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.control_out = out_data_r;

  // A clear command leaves the stored error and sum at zero.
  a_clear_state: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v0_r && clear0) |=> (prev_err_r == '0 && err_sum_r == '0))
    else $error("stored state not cleared by a clear command");

  // After an update the integral lies within the limit in force at that edge.
  a_sum_clamped: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v0_r) |=>
      ((SUM_W+1)'(err_sum_r) <= $past(int_lim) &&
       (SUM_W+1)'(err_sum_r) >= -$past(int_lim)))
    else $error("error sum outside the integral limit");

  // A clear command reaching the last stage produces a zero result.
  a_clear_output: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && v2_r && clr2_r) |=> (out_valid_r && out_data_r == '0))
    else $error("clear command did not produce a zero result");

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench of the clamped positional PID controller
// A queue-fed driver sends update and clear commands with random gaps, and
// a monitor takes the results with random stalls. Each result is checked
// against a control-law predictor that keeps its own error history, clamped
// error sum and register copy. A directed part covers the field extremes and
// limit corner cases; random phases with fresh register settings follow.
// ---------------------------------------------------------------------------
module tb;
  import pid_pkg::*;

  // Spare codes: func 3 behaves as a clear, indexes 6 and 7 are ignored.
  localparam logic [1:0]           FUNC_SPARE  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam int MAX_WAIT        = 14;
  localparam int RANDOM_ITEMS    = 1400;
  localparam int ITEMS_PER_PHASE = 100;
  localparam int DRAIN_CYCLES    = 20;
  localparam int CYCLE_LIMIT     = 500000;

  typedef struct packed {
    logic [1:0]                 func;
    logic signed [SAMPLE_W-1:0] sample;
  } cmd_t;

  logic clk = 1'b0;
  logic rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pid_in_if  in_ch ();
  pid_out_if out_ch ();

  pid_controller_clamped uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Predictor state and register copy.
  cfg_t                      ctl_cfg;
  logic signed [ERR_W-1:0]   ctl_prev_err;
  logic signed [SUM_W-1:0]   ctl_err_sum;

  cmd_t                      cmd_pending[$];
  logic signed [OUT_W-1:0]   ctrl_expected[$];

  logic        in_fire   = 1'b0;
  logic        no_idle   = 1'b0;
  int unsigned send_gap  = 0;
  int unsigned take_stall = 0;
  int unsigned errors    = 0;
  int unsigned cycles    = 0;

  // Clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Waiting time drawn for each transaction on either side.
  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
  endfunction

  // Control law: error, clamped sum, derivative, Q8.8 gains, saturation.
  function automatic logic signed [OUT_W-1:0] pid_predict(input logic [1:0] f,
                                                         input logic signed [SAMPLE_W-1:0] s);
    longint err, diff, sum, acc, y, ilim, olim;
    if (f == FUNC_CLEAR || f == FUNC_SPARE) begin
      ctl_prev_err = '0;
      ctl_err_sum  = '0;
      return '0;
    end
    if (f == FUNC_MEAS)
      err = longint'($signed(ctl_cfg.target_value)) - longint'(s);
    else
      err = longint'(s);
    diff = err - longint'(ctl_prev_err);
    sum  = longint'(ctl_err_sum) + err;
    ilim = longint'(ctl_cfg.integral_limit);
    if (sum > ilim) sum = ilim;
    if (sum < -ilim) sum = -ilim;
    ctl_prev_err = ERR_W'(err);
    ctl_err_sum  = SUM_W'(sum);
    acc = longint'($signed(ctl_cfg.gain_p)) * err
        + longint'($signed(ctl_cfg.gain_i)) * sum
        + longint'($signed(ctl_cfg.gain_d)) * diff;
    // Arithmetic shift of a signed value rounds toward minus infinity.
    y = acc >>> FRAC_W;
    olim = longint'(ctl_cfg.drive_limit);
    if (y > olim) y = olim;
    if (y < -olim) y = -olim;
    return OUT_W'(y);
  endfunction

  task automatic report(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  // Cycle counter and run limit.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", ctrl_expected.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Monitor: check each result transaction, then predict each new command.
  always @(posedge clk) begin
    in_fire = rst_n && in_ch.valid && in_ch.ready;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (ctrl_expected.size() == 0)
        report($sformatf("control_out %0d with no result pending", out_ch.control_out));
      else if (out_ch.control_out !== ctrl_expected[0]) begin
        report($sformatf("control_out %0d, predicted %0d",
                         out_ch.control_out, ctrl_expected[0]));
        void'(ctrl_expected.pop_front());
      end else
        void'(ctrl_expected.pop_front());
      take_stall = draw_wait();
    end
    if (in_fire)
      ctrl_expected.push_back(pid_predict(in_ch.func, in_ch.sample));
  end

  // Driver: hold a command until taken, then wait its gap before the next.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (send_gap > 0) begin
        in_ch.valid <= 1'b0;
        send_gap--;
      end else if (cmd_pending.size() != 0) begin
        in_ch.func   <= cmd_pending[0].func;
        in_ch.sample <= cmd_pending[0].sample;
        in_ch.valid  <= 1'b1;
        void'(cmd_pending.pop_front());
        send_gap = draw_wait();
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side stalls.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (take_stall > 0) begin
      out_ch.ready <= 1'b0;
      take_stall--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send_cmd(input logic [1:0] f, input logic signed [SAMPLE_W-1:0] s);
    cmd_t c;
    c.func   = f;
    c.sample = s;
    cmd_pending.push_back(c);
  endtask

  // Wait until every command is taken and every result has come back.
  task automatic wait_idle();
    do @(posedge clk);
    while (cmd_pending.size() != 0 || in_ch.valid || ctrl_expected.size() != 0);
  endtask

  // One register write; the copy is updated at once since the block is idle.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      REG_GAIN_P:    ctl_cfg.gain_p         = data[GAIN_W-1:0];
      REG_GAIN_I:    ctl_cfg.gain_i         = data[GAIN_W-1:0];
      REG_GAIN_D:    ctl_cfg.gain_d         = data[GAIN_W-1:0];
      REG_TARGET:    ctl_cfg.target_value   = data[SAMPLE_W-1:0];
      REG_OUT_LIMIT: ctl_cfg.drive_limit    = data[LIMIT_W-1:0];
      REG_INT_LIMIT: ctl_cfg.integral_limit = data[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random 16-bit register value with random unused upper bits.
  function automatic logic [CFG_DATA_W-1:0] pick_word();
    logic [CFG_DATA_W-1:0] v;
    v = CFG_DATA_W'($urandom);
    case ($urandom_range(0, 9))
      0: v[15:0] = 16'h7FFF;
      1: v[15:0] = 16'h8000;
      2: v[15:0] = 16'h0000;
      3, 4, 5: v[15:0] = 16'($urandom_range(0, 1023)) - 16'd512;
      default: ;
    endcase
    return v;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_limit();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return RESET_DRIVE_LIMIT;
      3, 4, 5: return CFG_DATA_W'($urandom_range(1, 70000));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  task automatic random_config();
    cfg_write(REG_GAIN_P, pick_word());
    cfg_write(REG_GAIN_I, pick_word());
    cfg_write(REG_GAIN_D, pick_word());
    cfg_write(REG_TARGET, pick_word());
    cfg_write(REG_OUT_LIMIT, pick_limit());
    cfg_write(REG_INT_LIMIT, pick_limit());
    if ($urandom_range(0, 1) == 0) begin
      cfg_write(REG_SPARE_A, CFG_DATA_W'($urandom));
      cfg_write(REG_SPARE_B, CFG_DATA_W'($urandom));
    end
    cfg_done();
  endtask

  // Stimulus.
  initial begin
    int unsigned bias;
    int unsigned r;
    logic signed [SAMPLE_W-1:0] s;
    logic [1:0] f;

    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_index    = '0;
    cfg_wdata    = '0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_MEAS;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    ctl_cfg      = '0;
    ctl_cfg.drive_limit    = RESET_DRIVE_LIMIT;
    ctl_cfg.integral_limit = RESET_INTEGRAL_LIMIT;
    ctl_prev_err = '0;
    ctl_err_sum  = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero gains give zero output while the sum builds up.
    send_cmd(FUNC_MEAS, 16'sh8000);
    send_cmd(FUNC_ERROR, 16'sh7FFF);

    // Extreme gains and setpoint, widest limits.
    wait_idle();
    cfg_write(REG_GAIN_P, 23'h7F7FFF);
    cfg_write(REG_GAIN_I, 23'h008000);
    cfg_write(REG_GAIN_D, 23'h007FFF);
    cfg_write(REG_TARGET, 23'h7F8000);
    cfg_write(REG_OUT_LIMIT, '1);
    cfg_write(REG_INT_LIMIT, '1);
    cfg_done();
    send_cmd(FUNC_MEAS, 16'sh7FFF);
    send_cmd(FUNC_MEAS, 16'sh8000);
    send_cmd(FUNC_ERROR, 16'sh8000);
    send_cmd(FUNC_ERROR, 16'sh7FFF);
    send_cmd(FUNC_CLEAR, 16'sh1234);
    send_cmd(FUNC_ERROR, 16'sh7FFF);
    send_cmd(FUNC_SPARE, 16'shFFFF);
    send_cmd(FUNC_MEAS, 16'sh0000);

    // Opposite extremes with zero limits: output and sum stay at zero.
    wait_idle();
    cfg_write(REG_GAIN_P, 23'h008000);
    cfg_write(REG_GAIN_I, 23'h007FFF);
    cfg_write(REG_GAIN_D, 23'h008000);
    cfg_write(REG_TARGET, 23'h007FFF);
    cfg_write(REG_OUT_LIMIT, '0);
    cfg_write(REG_INT_LIMIT, '0);
    cfg_done();
    send_cmd(FUNC_MEAS, 16'sh8000);
    send_cmd(FUNC_ERROR, 16'sh8000);

    // Unit gains, small limits: the sum saturates at the upper limit.
    wait_idle();
    cfg_write(REG_GAIN_P, 23'd256);
    cfg_write(REG_GAIN_I, 23'd256);
    cfg_write(REG_GAIN_D, 23'd256);
    cfg_write(REG_OUT_LIMIT, 23'd1000);
    cfg_write(REG_INT_LIMIT, 23'd70000);
    cfg_done();
    send_cmd(FUNC_ERROR, 16'sh7FFF);
    send_cmd(FUNC_ERROR, 16'sh7FFF);
    send_cmd(FUNC_ERROR, 16'sh7FFF);
    send_cmd(FUNC_ERROR, 16'sh8000);
    send_cmd(FUNC_ERROR, 16'sh8000);
    send_cmd(FUNC_ERROR, 16'sh8000);

    // Integral limit lowered below the stored sum, plus ignored indexes.
    wait_idle();
    cfg_write(REG_INT_LIMIT, 23'd100);
    cfg_write(REG_SPARE_A, '1);
    cfg_write(REG_SPARE_B, 23'h555555);
    cfg_done();
    send_cmd(FUNC_ERROR, 16'sh0000);
    send_cmd(FUNC_ERROR, -16'sd1);
    send_cmd(FUNC_MEAS, 16'sh0005);

    // Random phases, each with fresh register settings and its own idling.
    for (int p = 0; p < RANDOM_ITEMS / ITEMS_PER_PHASE; p++) begin
      wait_idle();
      random_config();
      no_idle = ($urandom_range(0, 3) == 0);
      bias    = $urandom_range(0, 3);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        r = $urandom_range(0, 99);
        if (r < 45) f = FUNC_MEAS;
        else if (r < 92) f = FUNC_ERROR;
        else if (r < 97) f = FUNC_CLEAR;
        else f = FUNC_SPARE;
        r = $urandom_range(0, 99);
        if (r < 12) s = ($urandom_range(0, 1) != 0) ? 16'sh7FFF : 16'sh8000;
        else if (bias == 1) s = SAMPLE_W'($urandom_range(0, 32767));
        else if (bias == 2) s = -SAMPLE_W'($urandom_range(1, 32768));
        else if (r < 30) s = SAMPLE_W'($urandom_range(0, 64)) - 16'sd32;
        else s = SAMPLE_W'($urandom);
        send_cmd(f, s);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
